// ----- src/gpgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Gripper pressure grip controller package
// Shared types and constants for the front, queue and back parts.
// ----------------------------------------------------------------------------
package gpgc_pkg;

	localparam logic [7:0]  ANGLE_OPEN  = 8'd60;
	localparam logic [7:0]  ANGLE_STOP  = 8'd90;
	localparam logic [7:0]  ANGLE_CLOSE = 8'd120;
	localparam logic [15:0] STEP_HOLD   = 16'd15;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRIP_THRESHOLD     = 3'd0,
		REG_DEBOUNCE_MS        = 3'd1,
		REG_SLOW_CLOSE_MS      = 3'd2,
		REG_CLOSE_TIMEOUT_MS   = 3'd3,
		REG_OPEN_HOLD_LIMIT_MS = 3'd4,
		REG_SLIP_MARGIN        = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  grip_threshold;
		logic [15:0] debounce_ms;
		logic [15:0] slow_close_ms;
		logic [15:0] close_timeout_ms;
		logic [15:0] open_hold_limit_ms;
		logic [7:0]  slip_margin;
	} cfg_t;

	// What the back part has to emit for one accepted word.
	typedef enum logic [2:0] {
		CMD_SLIP    = 3'd0,
		CMD_CLOSE   = 3'd1,
		CMD_TIMEOUT = 3'd2,
		CMD_HOLD    = 3'd3,
		CMD_OPEN    = 3'd4
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] hold;
		logic        err;
		logic        grip;
	} entry_t;

endpackage

// ----- src/gripper_pressure_grip_controller.sv -----
// An accepted word enters the queue, then the back part's output register.
// One word per cycle while the queue has room; an open command drives two result
// words, holding the output port for both, and a four-entry queue absorbs the burst.
// The grip state update is combinational in the front part, so words need no spacing.
// Reset clears the grip state, the queue pointers and the output valid flag, and
// loads the register defaults; the configuration port is always ready.
// ----------------------------------------------------------------------------
// Gripper pressure grip controller
// Configuration registers, front decision part, command queue and back part.
// ----------------------------------------------------------------------------
module gripper_pressure_grip_controller import gpgc_pkg::*; #(
	parameter int TIME_WIDTH  = 32,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic [TIME_WIDTH-1:0]  now_ms,
	input  logic [SAMPLE_BITS-1:0] raw_pressure,
	input  logic                   close_request,
	input  logic [TIME_WIDTH-1:0]  close_start_ms,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   servo_write,
	output logic [7:0]             servo_angle,
	output logic [15:0]            hold_ms,
	output logic                   done_res,
	output logic                   error_flag,
	output logic                   gripped_flag,
	output logic                   last
);

	cfg_t   cfg_q;
	logic   push;
	entry_t push_data;
	logic   full;
	logic   pop;
	entry_t pop_data;
	logic   empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grip_threshold     <= 8'd20;
			cfg_q.debounce_ms        <= 16'd10;
			cfg_q.slow_close_ms      <= 16'd800;
			cfg_q.close_timeout_ms   <= 16'd1000;
			cfg_q.open_hold_limit_ms <= 16'd1000;
			cfg_q.slip_margin        <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRIP_THRESHOLD:     cfg_q.grip_threshold     <= cfg_data[7:0];
				REG_DEBOUNCE_MS:        cfg_q.debounce_ms        <= cfg_data;
				REG_SLOW_CLOSE_MS:      cfg_q.slow_close_ms      <= cfg_data;
				REG_CLOSE_TIMEOUT_MS:   cfg_q.close_timeout_ms   <= cfg_data;
				REG_OPEN_HOLD_LIMIT_MS: cfg_q.open_hold_limit_ms <= cfg_data;
				REG_SLIP_MARGIN:        cfg_q.slip_margin        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	gpgc_front #(
		.TIME_WIDTH  (TIME_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.now_ms         (now_ms),
		.raw_pressure   (raw_pressure),
		.close_request  (close_request),
		.close_start_ms (close_start_ms),
		.push           (push),
		.push_data      (push_data),
		.full           (full)
	);

	gpgc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	gpgc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_data     (pop_data),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.servo_write  (servo_write),
		.servo_angle  (servo_angle),
		.hold_ms      (hold_ms),
		.done_res     (done_res),
		.error_flag   (error_flag),
		.gripped_flag (gripped_flag),
		.last         (last)
	);

endmodule

// ----- src/gpgc_front.sv -----
// ----------------------------------------------------------------------------
// Gripper controller front part
// Accepts words, runs the grip/release decision and state update, and queues
// a command for the back part.
// ----------------------------------------------------------------------------
module gpgc_front import gpgc_pkg::*; #(
	parameter int TIME_WIDTH  = 32,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic [TIME_WIDTH-1:0]  now_ms,
	input  logic [SAMPLE_BITS-1:0] raw_pressure,
	input  logic                   close_request,
	input  logic [TIME_WIDTH-1:0]  close_start_ms,
	output logic                   push,
	output entry_t                 push_data,
	input  logic                   full
);

	localparam logic [SAMPLE_BITS:0] SAMPLE_TOP = (SAMPLE_BITS+1)'((1 << SAMPLE_BITS) - 1);

	logic [7:0]            prev_q;
	logic [8:0]            ref_q;
	logic [7:0]            base_q;
	logic [TIME_WIDTH-1:0] last_eval_q;
	logic                  gripped_q;
	logic                  err_q;
	logic [TIME_WIDTH-1:0] closing_q;

	logic [SAMPLE_BITS+7:0] scaled;
	logic [7:0]             quot0;
	logic [SAMPLE_BITS:0]   rem0;
	logic [7:0]             mapped;
	logic signed [9:0]      diff;
	logic signed [9:0]      cur;
	logic signed [10:0]     cur11;
	logic signed [10:0]     ref11;
	logic signed [10:0]     thr11;
	logic                   eval_due;
	logic                   grip_hit;
	logic                   rel_hit;
	logic                   slip_hit;
	logic [TIME_WIDTH-1:0]  start;
	logic [TIME_WIDTH-1:0]  span;

	logic [8:0]            ref_n;
	logic [7:0]            base_n;
	logic                  gripped_n;
	logic                  err_n;
	logic [TIME_WIDTH-1:0] closing_n;
	entry_t                entry;

	// raw*255/top with top = 2^SAMPLE_BITS-1: since 2^S = top+1, the quotient by
	// 2^S plus one correction step gives the exact floor.
	always_comb begin
		scaled = {raw_pressure, 8'd0} - (SAMPLE_BITS+8)'(raw_pressure);
		quot0  = scaled[SAMPLE_BITS+7:SAMPLE_BITS];
		rem0   = {1'b0, scaled[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(quot0);
		mapped = (rem0 >= SAMPLE_TOP) ? quot0 + 8'd1 : quot0;
	end

	always_comb begin
		diff  = $signed({2'b00, mapped}) - $signed({2'b00, prev_q});
		cur   = ((diff == 10'sd0) || (diff == 10'sd1) || (diff == -10'sd1)) ?
		        $signed({1'b0, ref_q}) : diff;
		cur11 = {cur[9], cur};
		ref11 = $signed({2'b00, ref_q});
		thr11 = $signed({3'b000, cfg.grip_threshold});

		eval_due = (now_ms - last_eval_q) >= TIME_WIDTH'(cfg.debounce_ms);
		grip_hit = close_request && (cur11 >= ref11 + thr11);
		rel_hit  = (cur11 <= ref11 - thr11) && (ref_q > 9'd1);
		slip_hit = gripped_q && ($signed({2'b00, mapped}) <=
		           $signed({2'b00, base_q}) - $signed({2'b00, cfg.slip_margin}));

		start = err_q ? now_ms : close_start_ms;
		span  = now_ms - start;
	end

	always_comb begin
		ref_n     = ref_q;
		base_n    = base_q;
		gripped_n = gripped_q;
		err_n     = err_q;
		closing_n = closing_q;
		entry     = '{cmd: CMD_SLIP, hold: 16'd0, err: 1'b0, grip: 1'b0};

		if (operation) begin
			if (slip_hit) begin
				err_n = 1'b1;
			end
		end else begin
			if (eval_due) begin
				// With a zero threshold both compares can hold; grip wins.
				if (grip_hit) begin
					ref_n     = cur[8:0];
					base_n    = mapped;
					gripped_n = 1'b1;
					closing_n = span;
					err_n     = span > TIME_WIDTH'(cfg.slow_close_ms);
				end else if (rel_hit) begin
					ref_n     = cur[9] ? 9'd0 : cur[8:0];
					gripped_n = 1'b0;
				end
			end

			if (close_request) begin
				if (gripped_n) begin
					entry.cmd  = CMD_HOLD;
					entry.hold = STEP_HOLD;
				end else if (span > TIME_WIDTH'(cfg.close_timeout_ms)) begin
					err_n      = 1'b1;
					entry.cmd  = CMD_TIMEOUT;
					entry.hold = 16'd0;
				end else begin
					entry.cmd  = CMD_CLOSE;
					entry.hold = STEP_HOLD;
				end
			end else begin
				err_n     = 1'b0;
				entry.cmd = CMD_OPEN;
				if ((closing_n != '0) &&
				    (closing_n <= TIME_WIDTH'(cfg.open_hold_limit_ms))) begin
					entry.hold = closing_n[15:0];
				end else begin
					entry.hold = cfg.open_hold_limit_ms;
				end
			end
		end

		entry.err  = err_n;
		entry.grip = gripped_n;
	end

	assign in_ready  = !full;
	assign push      = in_valid && in_ready;
	assign push_data = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			ref_q       <= '0;
			base_q      <= '0;
			last_eval_q <= '0;
			gripped_q   <= 1'b0;
			err_q       <= 1'b0;
			closing_q   <= '0;
		end else if (push) begin
			ref_q     <= ref_n;
			base_q    <= base_n;
			gripped_q <= gripped_n;
			err_q     <= err_n;
			closing_q <= closing_n;
			if (!operation && eval_due) begin
				last_eval_q <= now_ms;
				prev_q      <= mapped;
			end
		end
	end

endmodule

// ----- src/gpgc_fifo.sv -----
// ----------------------------------------------------------------------------
// Gripper controller command queue
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module gpgc_fifo import gpgc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	entry_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;

	assign full     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

endmodule

// ----- src/gpgc_back.sv -----
// ----------------------------------------------------------------------------
// Gripper controller back part
// Turns queued commands into result words in an output register; an open
// command gives two words.
// ----------------------------------------------------------------------------
module gpgc_back import gpgc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      pop_data,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        servo_write,
	output logic [7:0]  servo_angle,
	output logic [15:0] hold_ms,
	output logic        done_res,
	output logic        error_flag,
	output logic        gripped_flag,
	output logic        last
);

	logic        valid_q;
	logic        phase_q;
	logic        write_q;
	logic [7:0]  angle_q;
	logic [15:0] hold_q;
	logic        done_q;
	logic        err_q;
	logic        grip_q;
	logic        last_q;

	logic        load;
	logic        write_n;
	logic [7:0]  angle_n;
	logic        done_n;
	logic        last_n;

	assign load = !valid_q || out_ready;
	assign pop  = load && !phase_q && !empty;

	always_comb begin
		write_n = 1'b1;
		angle_n = ANGLE_STOP;
		done_n  = 1'b0;
		last_n  = 1'b1;
		unique case (pop_data.cmd)
			CMD_SLIP: begin
				write_n = 1'b0;
				angle_n = 8'd0;
			end
			CMD_CLOSE: begin
				angle_n = ANGLE_CLOSE;
			end
			CMD_TIMEOUT: begin
				done_n = 1'b1;
			end
			CMD_HOLD: begin
				done_n = 1'b1;
			end
			CMD_OPEN: begin
				angle_n = ANGLE_OPEN;
				last_n  = 1'b0;
			end
			default: begin
				write_n = 1'b0;
				angle_n = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			if (phase_q) begin
				valid_q <= 1'b1;
				phase_q <= 1'b0;
			end else begin
				valid_q <= !empty;
				phase_q <= !empty && (pop_data.cmd == CMD_OPEN);
			end
		end
	end

	// The stop word after an open keeps the error and gripped bits already held.
	always_ff @(posedge clk) begin
		if (load) begin
			if (phase_q) begin
				write_q <= 1'b1;
				angle_q <= ANGLE_STOP;
				hold_q  <= 16'd0;
				done_q  <= 1'b0;
				last_q  <= 1'b1;
			end else if (!empty) begin
				write_q <= write_n;
				angle_q <= angle_n;
				hold_q  <= pop_data.hold;
				done_q  <= done_n;
				err_q   <= pop_data.err;
				grip_q  <= pop_data.grip;
				last_q  <= last_n;
			end
		end
	end

	assign out_valid    = valid_q;
	assign servo_write  = write_q;
	assign servo_angle  = angle_q;
	assign hold_ms      = hold_q;
	assign done_res     = done_q;
	assign error_flag   = err_q;
	assign gripped_flag = grip_q;
	assign last         = last_q;

	a_phase_shown: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> valid_q && !last_q && (angle_q == ANGLE_OPEN))
		else $error("second open word pending without first word shown");

	a_slip_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !write_q |-> last_q && (angle_q == 8'd0))
		else $error("slip check word not single");

endmodule
